// ===== hdl/fixed_point_expression_evaluator_defines.svh =====
// Assertion macros for the fixed-point expression evaluator checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef FIXED_POINT_EXPRESSION_EVALUATOR_DEFINES_SVH
`define FIXED_POINT_EXPRESSION_EVALUATOR_DEFINES_SVH

// Checked on every clock edge once reset has been released.
`define FPE_ASSERT_ACTIVE(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fpe_pkg.sv =====
// Shared types and constants for the fixed-point expression evaluator.
// Used by the divider, the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package fpe_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIV_BITS   = 2;

  localparam logic signed [VALUE_W-1:0] SCALE = 32'sd100;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [3:0] FW_TEN  = 4'd10;
  localparam logic [3:0] FW_ONE  = 4'd1;
  localparam logic [3:0] FW_NONE = 4'd0;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_BETWEEN  = 2'd0,
    PH_INTEGER  = 2'd1,
    PH_FRACTION = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic                         start;
    logic signed [DIVIDEND_W-1:0] dividend;
    logic signed [VALUE_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [VALUE_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/fpe_div.sv =====
// Iterative signed divider, 64-bit dividend by 32-bit divisor, truncating.
// Retires BITS_PER_CYCLE quotient bits per cycle. Depends on fpe_pkg.
`default_nettype none

module fpe_div
  import fpe_pkg::*;
#(
  parameter int unsigned BITS_PER_CYCLE = DIV_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int unsigned STEPS = DIVIDEND_W / BITS_PER_CYCLE;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [VALUE_W:0]      rem_r, rem_nxt;
  logic [VALUE_W:0]      dsr_r, dsr_nxt;
  logic [VALUE_W:0]      rem_v;
  logic [DIVIDEND_W-1:0] quo_v;
  logic [VALUE_W-1:0]    quo_low;

  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      rem_v = {rem_v[VALUE_W-1:0], quo_v[DIVIDEND_W-1]};
      quo_v = {quo_v[DIVIDEND_W-2:0], 1'b0};
      if (rem_v >= dsr_r) begin
        rem_v    = rem_v - dsr_r;
        quo_v[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = req.dividend[DIVIDEND_W-1] ^ req.divisor[VALUE_W-1];
      quo_nxt  = req.dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-req.dividend)
                                            : DIVIDEND_W'(req.dividend);
      dsr_nxt  = req.divisor[VALUE_W-1] ? {1'b0, VALUE_W'(-req.divisor)}
                                        : {1'b0, VALUE_W'(req.divisor)};
    end else if (busy_r) begin
      quo_nxt = quo_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quo_low      = quo_r[VALUE_W-1:0];
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? $signed(-quo_low) : $signed(quo_low);

endmodule

`default_nettype wire

// ===== hdl/fixed_point_expression_evaluator.sv =====
// Top level of the fixed-point expression evaluator: character decoder,
// sequencer and accumulator around the shared divider. Depends on fpe_pkg, fpe_div.
//
// Usage: expression text arrives one character per item on the in_ channel,
// with last set on the final character. Numbers carry up to two fraction
// digits and are held scaled by 100; operators apply strictly left to right.
// One result item (value scaled by 100, divide_by_zero flag) leaves on the
// out_ channel after each item marked last, and the expression state clears.
// Sequencing: a character that completes no number is absorbed in S_IDLE. Ending a
// number under add or subtract, or a divide by zero that is skipped, passes
// through S_APPLY; under multiply or a divide by a nonzero number it also
// passes through S_DIV_START and S_DIV_WAIT, where the divider retires
// DIV_RADIX quotient bits per cycle. An item marked last then passes through
// S_EMIT to load the output register. in_stall is high while an item is in work.
// Reset (rst_n low, synchronous) clears the expression state and the output valid flag.
// A stalled result holds in the output register; further characters are
// still taken, and the next result waits until the previous one is taken.
`default_nettype none

module fixed_point_expression_evaluator
  import fpe_pkg::*;
#(
  parameter int unsigned DIV_RADIX = DIV_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  state_t                    state_r, state_nxt;
  logic [VALUE_W-1:0]        acc_r, acc_nxt;
  logic [VALUE_W-1:0]        cur_r, cur_nxt;
  op_t                       op_r, op_nxt;
  op_t                       aop_r, aop_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [3:0]                fw_r, fw_nxt;
  logic                      dz_r, dz_nxt;
  logic [VALUE_W-1:0]        num_r, num_nxt;
  logic                      last_r, last_nxt;
  logic signed [DIVIDEND_W-1:0] prod_r, prod_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      is_digit;
  logic [3:0]                digit_val;
  logic [VALUE_W-1:0]        btw_cur;
  phase_t                    btw_phase;
  op_t                       btw_op;
  logic [VALUE_W-1:0]        ch_cur;
  phase_t                    ch_phase;
  op_t                       ch_op;
  logic [3:0]                ch_fw;
  logic                      ch_apply;
  logic [VALUE_W-1:0]        ch_num;
  logic signed [VALUE_W-1:0] mul_b;
  logic signed [DIVIDEND_W-1:0] mul_p;
  state_t                    after_apply;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  fpe_div #(
    .BITS_PER_CYCLE(DIV_RADIX)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign is_digit  = (in_item.character >= CH_ZERO) && (in_item.character <= CH_NINE);
  assign digit_val = in_item.character[3:0];

  always_comb begin
    btw_cur   = cur_r;
    btw_phase = PH_BETWEEN;
    btw_op    = op_r;
    if (is_digit) begin
      btw_cur   = VALUE_W'(digit_val);
      btw_phase = PH_INTEGER;
    end else if (in_item.character == CH_PLUS) begin
      btw_op = OP_ADD;
    end else if (in_item.character == CH_MINUS) begin
      btw_op = OP_SUB;
    end else if ((in_item.character == CH_STAR) || (in_item.character == CH_X)) begin
      btw_op = OP_MUL;
    end else if (in_item.character == CH_SLASH) begin
      btw_op = OP_DIV;
    end
  end

  always_comb begin
    ch_cur   = cur_r;
    ch_phase = phase_r;
    ch_op    = op_r;
    ch_fw    = fw_r;
    ch_apply = 1'b0;
    ch_num   = cur_r;
    case (phase_r)
      PH_INTEGER: begin
        if (is_digit) begin
          ch_cur = {cur_r[VALUE_W-4:0], 3'b000} + {cur_r[VALUE_W-2:0], 1'b0}
                 + VALUE_W'(digit_val);
        end else if (in_item.character == CH_DOT) begin
          ch_cur   = cur_r * VALUE_W'(SCALE);
          ch_fw    = FW_TEN;
          ch_phase = PH_FRACTION;
        end else begin
          ch_apply = 1'b1;
          ch_num   = cur_r * VALUE_W'(SCALE);
          ch_cur   = btw_cur;
          ch_phase = btw_phase;
          ch_op    = btw_op;
        end
      end
      PH_FRACTION: begin
        if (is_digit) begin
          if (fw_r != FW_NONE) begin
            ch_cur = cur_r + VALUE_W'(8'(digit_val) * 8'(fw_r));
            ch_fw  = (fw_r == FW_TEN) ? FW_ONE : FW_NONE;
          end
        end else begin
          ch_apply = 1'b1;
          ch_num   = cur_r;
          ch_cur   = btw_cur;
          ch_phase = btw_phase;
          ch_op    = btw_op;
        end
      end
      default: begin
        ch_cur   = btw_cur;
        ch_phase = btw_phase;
        ch_op    = btw_op;
      end
    endcase
    if (in_item.last && !ch_apply) begin
      if (ch_phase == PH_INTEGER) begin
        ch_apply = 1'b1;
        ch_num   = ch_cur * VALUE_W'(SCALE);
      end else if (ch_phase == PH_FRACTION) begin
        ch_apply = 1'b1;
        ch_num   = ch_cur;
      end
    end
  end

  assign mul_b       = (aop_r == OP_MUL) ? $signed(num_r) : SCALE;
  assign mul_p       = $signed(acc_r) * mul_b;
  assign after_apply = last_r ? S_EMIT : S_IDLE;

  always_comb begin
    state_nxt        = state_r;
    acc_nxt          = acc_r;
    cur_nxt          = cur_r;
    op_nxt           = op_r;
    aop_nxt          = aop_r;
    phase_nxt        = phase_r;
    fw_nxt           = fw_r;
    dz_nxt           = dz_r;
    num_nxt          = num_r;
    last_nxt         = last_r;
    prod_nxt         = prod_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_item_nxt     = out_item_r;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = (aop_r == OP_MUL) ? SCALE : $signed(num_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt   = ch_cur;
          phase_nxt = ch_phase;
          op_nxt    = ch_op;
          fw_nxt    = ch_fw;
          num_nxt   = ch_num;
          aop_nxt   = op_r;
          last_nxt  = in_item.last;
          if (ch_apply) begin
            state_nxt = S_APPLY;
          end else if (in_item.last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_APPLY: begin
        case (aop_r)
          OP_ADD: begin
            acc_nxt   = acc_r + num_r;
            state_nxt = after_apply;
          end
          OP_SUB: begin
            acc_nxt   = acc_r - num_r;
            state_nxt = after_apply;
          end
          OP_MUL: begin
            prod_nxt  = mul_p;
            state_nxt = S_DIV_START;
          end
          default: begin
            if (num_r == '0) begin
              dz_nxt    = 1'b1;
              state_nxt = after_apply;
            end else begin
              prod_nxt  = mul_p;
              state_nxt = S_DIV_START;
            end
          end
        endcase
      end
      S_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          acc_nxt   = VALUE_W'(div_rsp.quotient);
          state_nxt = after_apply;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.value          = $signed(acc_r);
          out_item_nxt.divide_by_zero = dz_r;
          acc_nxt                     = '0;
          cur_nxt                     = '0;
          op_nxt                      = OP_ADD;
          phase_nxt                   = PH_BETWEEN;
          fw_nxt                      = FW_TEN;
          dz_nxt                      = 1'b0;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cur_r       <= '0;
      op_r        <= OP_ADD;
      aop_r       <= OP_ADD;
      phase_r     <= PH_BETWEEN;
      fw_r        <= FW_TEN;
      dz_r        <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cur_r       <= cur_nxt;
      op_r        <= op_nxt;
      aop_r       <= aop_nxt;
      phase_r     <= phase_nxt;
      fw_r        <= fw_nxt;
      dz_r        <= dz_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    prod_r     <= prod_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hdl/fpe_checker.sv =====
// Port-level checker for the fixed-point expression evaluator, bound to the top.
// Depends on fpe_pkg and fixed_point_expression_evaluator_defines.svh.
`default_nettype none

`include "fixed_point_expression_evaluator_defines.svh"

module fpe_checker
  import fpe_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `FPE_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `FPE_ASSERT_ACTIVE(a_last_blocks_input, (in_valid && !in_stall && in_item.last) |=> in_stall, "input taken right after a last item")
  `FPE_ASSERT_ACTIVE(a_result_while_busy, $rose(out_valid) |-> $past(in_stall), "result appeared while input was open")
  `FPE_ASSERT_ACTIVE(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled result changed")

endmodule

bind fixed_point_expression_evaluator fpe_checker u_fpe_checker (.*);

`default_nettype wire

// ===== dv/tb_fixed_point_expression_evaluator.sv =====
// Testbench for the fixed-point expression evaluator: directed and random
// expression text is compared against a built-in predictor of the evaluator.
// Depends on fpe_pkg and fixed_point_expression_evaluator.
`default_nettype none

module tb_fixed_point_expression_evaluator
  import fpe_pkg::*;
();

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int unsigned CHAR_TARGET = 1100;
  localparam int unsigned TAIL_START = 1000;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0]         character;
    bit                 last;
    bit                 typed;
    logic signed [31:0] value;
    bit                 dz;
  } script_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic [31:0] acc_r;
  logic [31:0] num_r;
  op_t         op_r;
  phase_t      ph_r;
  logic [3:0]  fw_r;
  logic        dz_r;

  out_item_t   pending_results[$];
  logic [7:0]  expr_text[$];
  logic [7:0]  op_chars[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_X, CH_SLASH};

  int unsigned errors = 0;
  int unsigned chars_sent = 0;
  int unsigned exprs_sent = 0;
  int unsigned results_checked = 0;
  int unsigned dz_results = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet_tail = 0;

  script_row_t script[24] = '{
    '{8'h00,    1'b1, 1'b1, 0,   1'b0},
    '{"7",      1'b0, 1'b0, 0,   1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 0,   1'b0},
    '{"0",      1'b1, 1'b1, 700, 1'b1},
    '{"9",      1'b0, 1'b0, 0,   1'b0},
    '{CH_DOT,   1'b0, 1'b0, 0,   1'b0},
    '{"9",      1'b0, 1'b0, 0,   1'b0},
    '{"9",      1'b0, 1'b0, 0,   1'b0},
    '{"9",      1'b0, 1'b0, 0,   1'b0},
    '{8'hFF,    1'b0, 1'b0, 0,   1'b0},
    '{CH_X,     1'b0, 1'b0, 0,   1'b0},
    '{"2",      1'b1, 1'b0, 0,   1'b0},
    '{CH_MINUS, 1'b0, 1'b0, 0,   1'b0},
    '{CH_DOT,   1'b0, 1'b0, 0,   1'b0},
    '{"5",      1'b0, 1'b0, 0,   1'b0},
    '{CH_DOT,   1'b0, 1'b0, 0,   1'b0},
    '{CH_STAR,  1'b0, 1'b0, 0,   1'b0},
    '{"3",      1'b1, 1'b0, 0,   1'b0},
    '{"4",      1'b0, 1'b0, 0,   1'b0},
    '{CH_PLUS,  1'b0, 1'b0, 0,   1'b0},
    '{CH_SPACE, 1'b0, 1'b0, 0,   1'b0},
    '{"6",      1'b0, 1'b0, 0,   1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 0,   1'b0},
    '{"8",      1'b1, 1'b0, 0,   1'b0}
  };

  fixed_point_expression_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_expression();
    acc_r = '0;
    num_r = '0;
    op_r  = OP_ADD;
    ph_r  = PH_BETWEEN;
    fw_r  = FW_TEN;
    dz_r  = 1'b0;
  endfunction

  function automatic void fold_number(logic [31:0] scaled);
    longint a;
    longint n;
    a = longint'(signed'(acc_r));
    n = longint'(signed'(scaled));
    case (op_r)
      OP_ADD: acc_r = acc_r + scaled;
      OP_SUB: acc_r = acc_r - scaled;
      OP_MUL: acc_r = 32'((a * n) / longint'(SCALE));
      default: begin
        if (n != 0) acc_r = 32'((a * longint'(SCALE)) / n);
        else dz_r = 1'b1;
      end
    endcase
  endfunction

  function automatic void take_symbol(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      num_r = {24'd0, c - CH_ZERO};
      ph_r  = PH_INTEGER;
    end else if (c == CH_PLUS) begin
      op_r = OP_ADD;
    end else if (c == CH_MINUS) begin
      op_r = OP_SUB;
    end else if (c == CH_STAR || c == CH_X) begin
      op_r = OP_MUL;
    end else if (c == CH_SLASH) begin
      op_r = OP_DIV;
    end
  endfunction

  function automatic bit evaluate_char(in_item_t it, output out_item_t res);
    logic [7:0]  c;
    logic        is_digit;
    logic [31:0] d;
    c = it.character;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    d = {24'd0, c - CH_ZERO};
    res = '0;
    case (ph_r)
      PH_INTEGER: begin
        if (is_digit) begin
          num_r = num_r * 32'd10 + d;
        end else if (c == CH_DOT) begin
          num_r = num_r * SCALE;
          fw_r  = FW_TEN;
          ph_r  = PH_FRACTION;
        end else begin
          fold_number(num_r * SCALE);
          ph_r = PH_BETWEEN;
          take_symbol(c);
        end
      end
      PH_FRACTION: begin
        if (is_digit) begin
          if (fw_r != FW_NONE) begin
            num_r = num_r + d * fw_r;
            fw_r  = (fw_r == FW_TEN) ? FW_ONE : FW_NONE;
          end
        end else begin
          fold_number(num_r);
          ph_r = PH_BETWEEN;
          take_symbol(c);
        end
      end
      default: begin
        ph_r = PH_BETWEEN;
        take_symbol(c);
      end
    endcase
    if (!it.last) return 1'b0;
    if (ph_r == PH_INTEGER) fold_number(num_r * SCALE);
    else if (ph_r == PH_FRACTION) fold_number(num_r);
    res.value = acc_r;
    res.divide_by_zero = dz_r;
    clear_expression();
    return 1'b1;
  endfunction

  task automatic send_char(logic [7:0] c, bit l, bit typed, out_item_t typed_res);
    in_item_t  it;
    out_item_t res;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    it.character = c;
    it.last = l;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (evaluate_char(it, res)) pending_results.push_back(typed ? typed_res : res);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic push_number();
    int n_int;
    if ($urandom_range(0, 7) == 0) begin
      expr_text.push_back(CH_ZERO);
      if ($urandom_range(0, 1) == 1) begin
        expr_text.push_back(CH_DOT);
        expr_text.push_back(CH_ZERO);
      end
      return;
    end
    n_int = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
    repeat (n_int) expr_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 1) begin
      expr_text.push_back(CH_DOT);
      repeat ($urandom_range(0, 4)) expr_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 15) == 0) expr_text.push_back(CH_DOT);
    end
  endtask

  task automatic build_expression();
    int terms;
    expr_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    terms = $urandom_range(1, 5);
    for (int t = 0; t < terms; t++) begin
      if (t > 0 || $urandom_range(0, 3) == 0) expr_text.push_back(op_chars[$urandom_range(0, 4)]);
      if ($urandom_range(0, 3) == 0) expr_text.push_back(CH_SPACE);
      push_number();
      if ($urandom_range(0, 9) == 0) expr_text.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) expr_text.push_back(CH_SPACE);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value %0d divide_by_zero %0b",
                 $time, out_item.value, out_item.divide_by_zero);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.divide_by_zero) dz_results++;
        if (out_item.value !== want.value) begin
          $display("%0t: value expected %0d got %0d", $time, want.value, out_item.value);
          errors++;
        end
        if (out_item.divide_by_zero !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero expected %0b got %0b",
                   $time, want.divide_by_zero, out_item.divide_by_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    out_item_t none;
    out_item_t fixed;
    none = '0;
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    clear_expression();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      fixed.value = script[i].value;
      fixed.divide_by_zero = script[i].dz;
      send_char(script[i].character, script[i].last, script[i].typed, fixed);
    end

    while (chars_sent < CHAR_TARGET) begin
      if (exprs_sent % 25 == 24) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      quiet_tail = (chars_sent >= TAIL_START);
      build_expression();
      foreach (expr_text[k]) send_char(expr_text[k], k == expr_text.size() - 1, 1'b0, none);
      exprs_sent++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d random expressions plus the directed script.",
             chars_sent, exprs_sent);
    $display("Checked %0d results, %0d of them with a skipped division by zero.",
             results_checked, dz_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/fpe_pkg.sv
hdl/fpe_div.sv
hdl/fixed_point_expression_evaluator.sv
hdl/fpe_checker.sv
dv/tb_fixed_point_expression_evaluator.sv
